// ===== sv/rspl_pkg.sv =====
// Shared types, constants and calibration coefficients for the range sensor peak linearizer.
`timescale 1ns / 1ps

package rspl_pkg;

  localparam int READ_W        = 14;
  localparam int COEF_W        = 50;
  localparam int NUM_W         = 63;
  localparam int QUO_W         = 50;
  localparam int REM_W         = 17;
  localparam int DIST_W        = 24;
  localparam int SEG_W         = 2;
  localparam int K_W           = 3;
  localparam int Q_FRAC        = 8;
  localparam int CFG_ADDR_W    = 2;
  localparam int IN_TDATA_W    = 16;
  localparam int OUT_TDATA_W   = 40;
  localparam int OUT_TUSER_W   = 3;
  localparam int WINDOW_LENGTH_DEF = 3;

  localparam logic [REM_W:0] X_SCALE     = 18'd10000;
  localparam logic [REM_W:0] UNIT_PER_CM = 18'd100000;
  localparam logic [NUM_W-1:0] HALF_X    = 63'd5000;
  localparam logic [NUM_W-1:0] HALF_UNIT = 63'd50000;

  localparam logic [QUO_W-1:0] Q8_POS_LIM = 50'd8388607;
  localparam logic [QUO_W-1:0] Q8_NEG_LIM = 50'd8388608;
  localparam logic [DIST_W-1:0] Q8_MAX    = 24'h7FFFFF;
  localparam logic [DIST_W-1:0] Q8_MIN    = 24'h800000;

  localparam logic [READ_W-1:0] LOW_LIMIT_RST  = 14'd506;
  localparam logic [READ_W-1:0] HIGH_LIMIT_RST = 14'd1253;

  localparam logic [CFG_ADDR_W-1:0] CFG_LOW_LIMIT  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_HIGH_LIMIT = 2'd1;

  localparam logic [SEG_W-1:0] SEG_CUBIC   = 2'd0;
  localparam logic [SEG_W-1:0] SEG_QUINTIC = 2'd1;
  localparam logic [SEG_W-1:0] SEG_QUAD    = 2'd2;

  typedef struct packed {
    logic start;
    logic wide;
  } rspl_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rspl_div_rsp_t;

  // Horner coefficients, highest power first, in units of 1e-5 cm
  function automatic logic signed [COEF_W-1:0] coef(input logic [SEG_W-1:0] seg,
                                                   input logic [K_W-1:0] k);
    logic signed [COEF_W-1:0] c;
    c = '0;
    case (seg)
      SEG_CUBIC: begin
        case (k)
          3'd0:    c = -50'sd12023716293000;
          3'd1:    c =  50'sd1721241165700;
          3'd2:    c = -50'sd82796230077;
          3'd3:    c =  50'sd1350000000;
          default: c = '0;
        endcase
      end
      SEG_QUINTIC: begin
        case (k)
          3'd0:    c = -50'sd16303911361000;
          3'd1:    c =  50'sd7959317371300;
          3'd2:    c = -50'sd1547775733300;
          3'd3:    c =  50'sd150551267600;
          3'd4:    c = -50'sd7407566463;
          3'd5:    c =  50'sd153051100;
          default: c = '0;
        endcase
      end
      SEG_QUAD: begin
        case (k)
          3'd0:    c = -50'sd169135570;
          3'd1:    c =  50'sd39972587;
          3'd2:    c = -50'sd347620;
          default: c = '0;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [K_W-1:0] last_k(input logic [SEG_W-1:0] seg);
    logic [K_W-1:0] r;
    case (seg)
      SEG_CUBIC:   r = 3'd3;
      SEG_QUINTIC: r = 3'd5;
      default:     r = 3'd2;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/rspl_sdiv.sv =====
// Bit-serial rounding divider by a constant scale (1e4 or 1e5), one quotient bit per cycle.
`timescale 1ns / 1ps

module rspl_sdiv (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rspl_pkg::rspl_div_req_t       req_i,
  input  logic [rspl_pkg::NUM_W-1:0]    num_i,
  output rspl_pkg::rspl_div_rsp_t       rsp_o,
  output logic [rspl_pkg::QUO_W-1:0]    quot_o
);

  localparam int CW = $clog2(rspl_pkg::QUO_W);

  logic                          run_q;
  logic                          done_q;
  logic                          wide_q;
  logic [CW-1:0]                 cnt_q;
  logic [rspl_pkg::REM_W-1:0]    rem_q;
  logic [rspl_pkg::QUO_W-1:0]    shift_q;

  logic [rspl_pkg::NUM_W-1:0]    num_rnd;
  logic [rspl_pkg::REM_W:0]      divisor;
  logic [rspl_pkg::REM_W:0]      trial;
  logic                          fits;

  assign num_rnd = num_i + (req_i.wide ? rspl_pkg::HALF_UNIT : rspl_pkg::HALF_X);
  assign divisor = wide_q ? rspl_pkg::UNIT_PER_CM : rspl_pkg::X_SCALE;
  assign trial   = {rem_q, shift_q[rspl_pkg::QUO_W-1]};
  assign fits    = (trial >= divisor);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      done_q  <= 1'b0;
      wide_q  <= 1'b0;
      cnt_q   <= '0;
      rem_q   <= '0;
      shift_q <= '0;
    end else begin
      done_q <= !req_i.start && run_q && (cnt_q == CW'(rspl_pkg::QUO_W - 1));
      if (req_i.start) begin
        run_q   <= 1'b1;
        wide_q  <= req_i.wide;
        cnt_q   <= '0;
        // top bits stay below either divisor, so they seed the remainder
        rem_q   <= rspl_pkg::REM_W'(num_rnd[rspl_pkg::NUM_W-1:rspl_pkg::QUO_W]);
        shift_q <= num_rnd[rspl_pkg::QUO_W-1:0];
      end else if (run_q) begin
        rem_q   <= fits ? rspl_pkg::REM_W'(trial - divisor) : trial[rspl_pkg::REM_W-1:0];
        shift_q <= {shift_q[rspl_pkg::QUO_W-2:0], fits};
        cnt_q   <= cnt_q + 1'b1;
        if (cnt_q == CW'(rspl_pkg::QUO_W - 1)) begin
          run_q  <= 1'b0;
        end
      end
    end
  end

  assign rsp_o.busy = run_q;
  assign rsp_o.done = done_q;
  assign quot_o     = shift_q;

endmodule

// ===== sv/range_sensor_peak_linearizer.sv =====
// Top level: reading window, serial peak scan, Horner evaluation and Q15.8 output stage.
//
//   channel  dir  handshake                    contents
//   s_axis   in   s_axis_tvalid_i/tready_o     raw_reading
//   m_axis   out  m_axis_tvalid_o/tready_i     distance_q8, peak_reading | segment, saturated
//   cfg      in   cfg_valid_i/cfg_ready_o      cfg_addr_i register index, cfg_data_i value
//
// An item that completes the window holds input off until its result enters the output
// register: the window is scanned, a segment is chosen and each Horner step runs as a
// shift-add multiply and a pass through the bit-serial divider, before a last divide
// scales the result. Items before the window is full are stored while input stays
// ready. Reset clears control state and loads the limit defaults.
// The result waits in the output register; a stalled output blocks input only
// when a newer result is ready to take its place.
`timescale 1ns / 1ps

module range_sensor_peak_linearizer #(
  parameter int WINDOW_LENGTH = rspl_pkg::WINDOW_LENGTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [rspl_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,   // [13:0] raw_reading
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [rspl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,   // [23:0] distance_q8, [37:24] peak_reading
  output logic [rspl_pkg::OUT_TUSER_W-1:0]    m_axis_tuser_o,   // [1:0] segment, [2] saturated
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rspl_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [rspl_pkg::READ_W-1:0]         cfg_data_i
);

  localparam int PW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int FW = $clog2(WINDOW_LENGTH + 1);
  localparam int MW = $clog2(rspl_pkg::READ_W);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SEG, S_MLOAD, S_MUL, S_DSTART, S_DWAIT, S_FLOAD, S_EMIT
  } state_e;

  state_e state_q;

  logic [rspl_pkg::READ_W-1:0]        win_q [WINDOW_LENGTH];
  logic [PW-1:0]                      pos_q;
  logic [FW-1:0]                      fill_q;
  logic [PW-1:0]                      idx_q;
  logic [rspl_pkg::READ_W-1:0]        low_q;
  logic [rspl_pkg::READ_W-1:0]        high_q;
  logic [rspl_pkg::READ_W-1:0]        peak_q;
  logic [rspl_pkg::SEG_W-1:0]         seg_q;
  logic [rspl_pkg::K_W-1:0]           k_q;
  logic                               final_q;
  logic                               neg_q;
  logic signed [rspl_pkg::COEF_W-1:0] t_q;
  logic [rspl_pkg::NUM_W-1:0]         mcand_q;
  logic [rspl_pkg::NUM_W-1:0]         acc_q;
  logic [rspl_pkg::READ_W-1:0]        mplier_q;
  logic [MW-1:0]                      mcnt_q;
  logic [rspl_pkg::DIST_W-1:0]        dist_q;
  logic                               sat_q;

  logic                               out_valid_q;
  logic [rspl_pkg::DIST_W-1:0]        out_dist_q;
  logic [rspl_pkg::READ_W-1:0]        out_peak_q;
  logic [rspl_pkg::SEG_W-1:0]         out_seg_q;
  logic                               out_sat_q;

  logic                               in_xfer;
  logic [rspl_pkg::READ_W-1:0]        reading;
  logic [rspl_pkg::READ_W-1:0]        win_rd;
  logic [rspl_pkg::COEF_W-1:0]        t_abs;
  logic signed [rspl_pkg::COEF_W-1:0] q_signed;
  logic signed [rspl_pkg::COEF_W-1:0] t_next;
  logic                               sat_c;
  logic [rspl_pkg::DIST_W-1:0]        dist_c;

  rspl_pkg::rspl_div_req_t            div_req;
  rspl_pkg::rspl_div_rsp_t            div_rsp;
  logic [rspl_pkg::QUO_W-1:0]         quot;

  assign reading         = s_axis_tdata_i[rspl_pkg::READ_W-1:0];
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign win_rd          = win_q[idx_q];

  assign t_abs    = t_q[rspl_pkg::COEF_W-1] ? unsigned'(-t_q) : unsigned'(t_q);
  assign q_signed = neg_q ? -$signed(quot) : $signed(quot);
  assign t_next   = q_signed + rspl_pkg::coef(seg_q, k_q);

  always_comb begin
    sat_c  = 1'b0;
    dist_c = rspl_pkg::DIST_W'(q_signed);
    if (!neg_q && (quot > rspl_pkg::Q8_POS_LIM)) begin
      sat_c  = 1'b1;
      dist_c = rspl_pkg::Q8_MAX;
    end else if (neg_q && (quot > rspl_pkg::Q8_NEG_LIM)) begin
      sat_c  = 1'b1;
      dist_c = rspl_pkg::Q8_MIN;
    end
  end

  assign div_req.start = (state_q == S_DSTART);
  assign div_req.wide  = final_q;

  rspl_sdiv u_sdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (acc_q),
    .rsp_o  (div_rsp),
    .quot_o (quot)
  );

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      win_q[pos_q] <= reading;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      fill_q      <= '0;
      idx_q       <= '0;
      low_q       <= rspl_pkg::LOW_LIMIT_RST;
      high_q      <= rspl_pkg::HIGH_LIMIT_RST;
      peak_q      <= '0;
      seg_q       <= rspl_pkg::SEG_CUBIC;
      k_q         <= '0;
      final_q     <= 1'b0;
      neg_q       <= 1'b0;
      t_q         <= '0;
      mcand_q     <= '0;
      acc_q       <= '0;
      mplier_q    <= '0;
      mcnt_q      <= '0;
      dist_q      <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_dist_q  <= '0;
      out_peak_q  <= '0;
      out_seg_q   <= rspl_pkg::SEG_CUBIC;
      out_sat_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_addr_i == rspl_pkg::CFG_LOW_LIMIT) begin
          low_q <= cfg_data_i;
        end else if (cfg_addr_i == rspl_pkg::CFG_HIGH_LIMIT) begin
          high_q <= cfg_data_i;
        end
      end

      if (out_valid_q && m_axis_tready_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            pos_q <= (pos_q == PW'(WINDOW_LENGTH - 1)) ? '0 : pos_q + 1'b1;
            if (fill_q != FW'(WINDOW_LENGTH)) begin
              fill_q <= fill_q + 1'b1;
            end
            if (fill_q >= FW'(WINDOW_LENGTH - 1)) begin
              idx_q   <= '0;
              peak_q  <= '0;
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (win_rd > peak_q) begin
            peak_q <= win_rd;
          end
          idx_q <= (idx_q == PW'(WINDOW_LENGTH - 1)) ? '0 : idx_q + 1'b1;
          if (idx_q == PW'(WINDOW_LENGTH - 1)) begin
            state_q <= S_SEG;
          end
        end
        S_SEG: begin
          if (peak_q < low_q) begin
            seg_q <= rspl_pkg::SEG_CUBIC;
            t_q   <= rspl_pkg::coef(rspl_pkg::SEG_CUBIC, '0);
          end else if (peak_q > high_q) begin
            seg_q <= rspl_pkg::SEG_QUAD;
            t_q   <= rspl_pkg::coef(rspl_pkg::SEG_QUAD, '0);
          end else begin
            seg_q <= rspl_pkg::SEG_QUINTIC;
            t_q   <= rspl_pkg::coef(rspl_pkg::SEG_QUINTIC, '0);
          end
          k_q     <= rspl_pkg::K_W'(1);
          final_q <= 1'b0;
          state_q <= S_MLOAD;
        end
        S_MLOAD: begin
          neg_q    <= t_q[rspl_pkg::COEF_W-1];
          mcand_q  <= rspl_pkg::NUM_W'(t_abs);
          acc_q    <= '0;
          mplier_q <= peak_q;
          mcnt_q   <= '0;
          state_q  <= S_MUL;
        end
        S_MUL: begin
          if (mplier_q[0]) begin
            acc_q <= acc_q + mcand_q;
          end
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
          mcnt_q   <= mcnt_q + 1'b1;
          if (mcnt_q == MW'(rspl_pkg::READ_W - 1)) begin
            state_q <= S_DSTART;
          end
        end
        S_DSTART: begin
          state_q <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_rsp.done) begin
            if (final_q) begin
              dist_q  <= dist_c;
              sat_q   <= sat_c;
              state_q <= S_EMIT;
            end else begin
              t_q <= t_next;
              if (k_q == rspl_pkg::last_k(seg_q)) begin
                state_q <= S_FLOAD;
              end else begin
                k_q     <= k_q + 1'b1;
                state_q <= S_MLOAD;
              end
            end
          end
        end
        S_FLOAD: begin
          neg_q   <= t_q[rspl_pkg::COEF_W-1];
          acc_q   <= rspl_pkg::NUM_W'(t_abs) << rspl_pkg::Q_FRAC;
          final_q <= 1'b1;
          state_q <= S_DSTART;
        end
        S_EMIT: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_dist_q  <= dist_q;
            out_peak_q  <= peak_q;
            out_seg_q   <= seg_q;
            out_sat_q   <= sat_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_peak_q, out_dist_q};
  assign m_axis_tuser_o  = {out_sat_q, out_seg_q};

  a_no_accept_while_dividing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> !s_axis_tready_o)
    else $error("input accepted while divider busy");

  a_sat_at_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_sat_q) |-> (out_dist_q == rspl_pkg::Q8_MAX ||
                                    out_dist_q == rspl_pkg::Q8_MIN))
    else $error("saturated flag without clipped distance");

  a_segment_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_seg_q == rspl_pkg::SEG_CUBIC || out_seg_q == rspl_pkg::SEG_QUINTIC ||
                     out_seg_q == rspl_pkg::SEG_QUAD))
    else $error("bad segment code on output");

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (fill_q == FW'(WINDOW_LENGTH)))
    else $error("evaluation started before window full");

endmodule
